[rtl/utf8_stream_decoder_macros.svh]
// Assertion macros for the UTF-8 stream decoder.
// Used by the decoder stage and the result sequencer; no other dependencies.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define UTF8SD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("utf8 stream decoder: assertion failed");
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 stream decoder: assertion failed");
`else
`define UTF8SD_ASSERT(lbl, clk, rst, prop)
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/utf8sd_pkg.sv]
// Types and constants shared by the UTF-8 stream decoder.
// No dependencies.
`default_nettype none

package utf8sd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [20:0] cp_type;
   typedef logic [2:0]  count_type;
   typedef logic [2:0]  len_type;
   typedef logic [1:0]  taken_type;

   typedef enum logic [1:0] {
      KIND_CP  = 2'd0,
      KIND_ERR = 2'd1,
      KIND_END = 2'd2
   } kind_type;

   // A burst is (count - 1) error beats followed by one final beat.
   typedef struct packed {
      count_type count;
      kind_type  kind;
      cp_type    code_point;
   } burst_type;

   localparam count_type MAX_RESULTS = 3'd4;

   localparam len_type LEN_NONE = 3'd0;
   localparam len_type LEN_TWO  = 3'd2;
   localparam len_type LEN_THREE = 3'd3;
   localparam len_type LEN_FOUR = 3'd4;

   localparam byte_type LEAD2_LO = 8'hC2;
   localparam byte_type LEAD2_HI = 8'hDF;
   localparam byte_type LEAD3_LO = 8'hE0;
   localparam byte_type LEAD3_HI = 8'hEF;
   localparam byte_type LEAD4_LO = 8'hF0;
   localparam byte_type LEAD4_HI = 8'hF4;
   localparam byte_type CONT_MASK = 8'hC0;
   localparam byte_type CONT_TAG  = 8'h80;

   localparam cp_type MIN_TWO   = 21'h000080;
   localparam cp_type MIN_THREE = 21'h000800;
   localparam cp_type MIN_FOUR  = 21'h010000;
   localparam cp_type SURR_LO   = 21'h00D800;
   localparam cp_type SURR_HI   = 21'h00DFFF;
   localparam cp_type CP_MAX    = 21'h10FFFF;

endpackage

`default_nettype wire

[rtl/utf8sd_channels.sv]
// Valid/ready channel interfaces for the UTF-8 stream decoder.
// Depends on utf8sd_pkg for the payload types.
`default_nettype none

interface utf8sd_req_if;
   logic                 valid;
   logic                 ready;
   utf8sd_pkg::byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface utf8sd_rsp_if;
   logic                 valid;
   logic                 ready;
   utf8sd_pkg::kind_type kind;
   utf8sd_pkg::cp_type   code_point;
   logic                 last;

   modport source (output valid, output kind, output code_point, output last, input ready);
   modport sink   (input valid, input kind, input code_point, input last, output ready);
endinterface

`default_nettype wire

[rtl/utf8_stream_decoder.sv]
// UTF-8 stream decoder: one byte per beat in, code points and errors out.
// A byte is held in the input register, then its results in the result register.
// Throughput: one byte per cycle while each byte gives at most one result and the
// result side is ready; a byte that gives more than one result holds the result register until its final beat is taken.
// Reset (synchronous, active high) drops any pending sequence and queued beats.
// Depends on utf8sd_pkg, utf8sd_channels, utf8sd_decode and utf8sd_emit.
`default_nettype none

module utf8_stream_decoder (
   input  wire logic    clock,
   input  wire logic    reset,
   utf8sd_req_if.sink   req_chan,
   utf8sd_rsp_if.source rsp_chan
);

   logic                  load;
   logic                  load_ok;
   utf8sd_pkg::burst_type burst;

   utf8sd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .load_ok  (load_ok),
      .load     (load),
      .burst    (burst)
   );

   utf8sd_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .burst    (burst),
      .load_ok  (load_ok),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[rtl/utf8sd_decode.sv]
// Input register, sequence state and per-byte decode into a result burst.
// Depends on utf8sd_pkg, utf8sd_channels and the assertion macro header.
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8sd_decode (
   input  wire logic               clock,
   input  wire logic               reset,
   utf8sd_req_if.sink              req_chan,
   input  wire logic               load_ok,
   output logic                    load,
   output utf8sd_pkg::burst_type   burst
);

   logic                  in_valid_ff, in_valid_in;
   utf8sd_pkg::byte_type  byte_ff;
   utf8sd_pkg::cp_type    pv_ff, pv_in;
   utf8sd_pkg::len_type   exp_ff, exp_in;
   utf8sd_pkg::taken_type taken_ff, taken_in;

   logic                  req_fire;
   logic                  pending;
   logic                  is_cont;
   logic                  lead_has;
   utf8sd_pkg::kind_type  lead_kind;
   utf8sd_pkg::cp_type    lead_cp;
   utf8sd_pkg::len_type   lead_len;
   utf8sd_pkg::cp_type    lead_pv;
   utf8sd_pkg::taken_type lead_taken;
   utf8sd_pkg::cp_type    acc;
   utf8sd_pkg::len_type   sum;
   utf8sd_pkg::cp_type    minimum;
   logic                  bad;

   assign req_chan.ready = !in_valid_ff || load_ok;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load           = in_valid_ff && load_ok;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Treatment of a byte as if no sequence were pending.
   always_comb begin
      lead_has   = 1'b0;
      lead_kind  = utf8sd_pkg::KIND_ERR;
      lead_cp    = '0;
      lead_len   = utf8sd_pkg::LEN_NONE;
      lead_pv    = '0;
      lead_taken = 2'd0;
      if (byte_ff == 8'd0) begin
         lead_has  = 1'b1;
         lead_kind = utf8sd_pkg::KIND_END;
      end else if (!byte_ff[7]) begin
         lead_has  = 1'b1;
         lead_kind = utf8sd_pkg::KIND_CP;
         lead_cp   = {13'd0, byte_ff};
      end else if (byte_ff >= utf8sd_pkg::LEAD2_LO && byte_ff <= utf8sd_pkg::LEAD2_HI) begin
         lead_len   = utf8sd_pkg::LEN_TWO;
         lead_pv    = {16'd0, byte_ff[4:0]};
         lead_taken = 2'd1;
      end else if (byte_ff >= utf8sd_pkg::LEAD3_LO && byte_ff <= utf8sd_pkg::LEAD3_HI) begin
         lead_len   = utf8sd_pkg::LEN_THREE;
         lead_pv    = {17'd0, byte_ff[3:0]};
         lead_taken = 2'd1;
      end else if (byte_ff >= utf8sd_pkg::LEAD4_LO && byte_ff <= utf8sd_pkg::LEAD4_HI) begin
         lead_len   = utf8sd_pkg::LEN_FOUR;
         lead_pv    = {18'd0, byte_ff[2:0]};
         lead_taken = 2'd1;
      end else begin
         lead_has = 1'b1;
      end
   end

   assign pending = (exp_ff == utf8sd_pkg::LEN_TWO) || (exp_ff == utf8sd_pkg::LEN_THREE)
                    || (exp_ff == utf8sd_pkg::LEN_FOUR);
   assign is_cont = (byte_ff & utf8sd_pkg::CONT_MASK) == utf8sd_pkg::CONT_TAG;
   assign acc     = {pv_ff[14:0], byte_ff[5:0]};
   assign sum     = {1'b0, taken_ff} + 3'd1;

   always_comb begin
      case (exp_ff)
         utf8sd_pkg::LEN_TWO:   minimum = utf8sd_pkg::MIN_TWO;
         utf8sd_pkg::LEN_THREE: minimum = utf8sd_pkg::MIN_THREE;
         default:               minimum = utf8sd_pkg::MIN_FOUR;
      endcase
   end

   assign bad = (acc < minimum)
                || (acc >= utf8sd_pkg::SURR_LO && acc <= utf8sd_pkg::SURR_HI)
                || (acc > utf8sd_pkg::CP_MAX);

   always_comb begin
      pv_in    = pv_ff;
      exp_in   = exp_ff;
      taken_in = taken_ff;
      burst    = '{count: 3'd0, kind: utf8sd_pkg::KIND_ERR, code_point: '0};
      if (load) begin
         if (!pending) begin
            pv_in    = lead_pv;
            exp_in   = lead_len;
            taken_in = lead_taken;
            burst    = '{count: {2'd0, lead_has}, kind: lead_kind, code_point: lead_cp};
         end else if (is_cont) begin
            if (sum >= exp_ff) begin
               pv_in    = '0;
               exp_in   = utf8sd_pkg::LEN_NONE;
               taken_in = 2'd0;
               if (bad) begin
                  burst = '{count: exp_ff, kind: utf8sd_pkg::KIND_ERR, code_point: '0};
               end else begin
                  burst = '{count: 3'd1, kind: utf8sd_pkg::KIND_CP, code_point: acc};
               end
            end else begin
               pv_in    = acc;
               taken_in = sum[1:0];
            end
         end else begin
            // The interrupted sequence costs one error per byte taken, then the
            // byte is handled again as a lead.
            pv_in    = lead_pv;
            exp_in   = lead_len;
            taken_in = lead_taken;
            burst.count = {1'b0, taken_ff} + {2'd0, lead_has};
            if (lead_has) begin
               burst.kind       = lead_kind;
               burst.code_point = lead_cp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pv_ff       <= '0;
         exp_ff      <= utf8sd_pkg::LEN_NONE;
         taken_ff    <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         pv_ff       <= pv_in;
         exp_ff      <= exp_in;
         taken_ff    <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_chan.data_byte;
      end
   end

   `UTF8SD_ASSERT(a_len_legal, clock, reset, exp_ff == utf8sd_pkg::LEN_NONE || pending)
   `UTF8SD_ASSERT(a_taken_range, clock, reset, (exp_ff == utf8sd_pkg::LEN_NONE) || (taken_ff != 2'd0 && {1'b0, taken_ff} < exp_ff))
   `UTF8SD_ASSERT(a_idle_clear, clock, reset, (exp_ff != utf8sd_pkg::LEN_NONE) || (pv_ff == '0 && taken_ff == 2'd0))

endmodule

`default_nettype wire

[rtl/utf8sd_emit.sv]
// Result register that plays out a burst one beat per cycle while the result side is ready.
// Depends on utf8sd_pkg, utf8sd_channels and the assertion macro header.
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8sd_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire utf8sd_pkg::burst_type burst,
   output logic                       load_ok,
   utf8sd_rsp_if.source               rsp_chan
);

   utf8sd_pkg::count_type cnt_ff, cnt_in;
   utf8sd_pkg::kind_type  kind_ff;
   utf8sd_pkg::cp_type    cp_ff;
   logic                  rsp_fire;

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   // A new burst may enter as the final beat of the current one leaves.
   assign load_ok  = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_chan.ready);

   always_comb begin
      if (load) begin
         cnt_in = burst.count;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 3'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   assign rsp_chan.valid      = cnt_ff != 3'd0;
   assign rsp_chan.last       = cnt_ff == 3'd1;
   assign rsp_chan.kind       = (cnt_ff > 3'd1) ? utf8sd_pkg::KIND_ERR : kind_ff;
   assign rsp_chan.code_point = (cnt_ff > 3'd1) ? '0 : cp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= burst.kind;
         cp_ff   <= burst.code_point;
      end
   end

   `UTF8SD_ASSERT(a_load_when_free, clock, reset, !load || cnt_ff == 3'd0 || (cnt_ff == 3'd1 && rsp_fire))
   `UTF8SD_ASSERT(a_count_bound, clock, reset, cnt_ff <= utf8sd_pkg::MAX_RESULTS)
   `UTF8SD_ASSERT_NEXT(a_burst_continues, clock, reset, rsp_fire && !rsp_chan.last, rsp_chan.valid && !load_ok || rsp_chan.valid)

endmodule

`default_nettype wire

[bench/tb_utf8_stream_decoder.sv]
`timescale 1ns / 1ps
// Self-checking bench for utf8_stream_decoder: byte stream in, checked results out.
// Depends on utf8sd_pkg, the utf8sd channel interfaces and the decoder RTL.

module tb_utf8_stream_decoder;

   localparam int RANDOM_BYTES = 300;
   localparam int QUIET_TAIL = 60;
   localparam int HOLD_CYCLES = 48;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;

   // Directed text: single bytes at the edges, every lead length, invalid scalars
   // of each kind, and sequences cut short by a letter and by a zero byte.
   localparam utf8sd_pkg::byte_type DIRECTED_TEXT [25] = '{
      8'h00, 8'h01, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF,
      8'hC2, 8'hA9,
      8'hE0, 8'h80, 8'h80,
      8'hED, 8'hA0, 8'h80,
      8'hF4, 8'h90, 8'h80, 8'h80,
      8'hF0, 8'h9F, 8'h98, 8'h41,
      8'hE2, 8'h00
   };

   typedef struct {
      utf8sd_pkg::kind_type kind;
      utf8sd_pkg::cp_type   code_point;
      logic                 last;
   } decoded_type;

   class utf8_scoreboard_type;
      utf8sd_pkg::len_type   seq_len;
      utf8sd_pkg::count_type seq_taken;
      utf8sd_pkg::cp_type    seq_bits;
      decoded_type           expected_q[$];
      int                    mismatches;
      int                    checked;
      int                    n_cp;
      int                    n_err;
      int                    n_end;

      function new();
         clear_seq();
         mismatches = 0;
         checked = 0;
         n_cp = 0;
         n_err = 0;
         n_end = 0;
      endfunction

      function void clear_seq();
         seq_len = utf8sd_pkg::LEN_NONE;
         seq_taken = '0;
         seq_bits = '0;
      endfunction

      function void push(utf8sd_pkg::kind_type k, utf8sd_pkg::cp_type cp);
         decoded_type d;
         d.kind = k;
         d.code_point = cp;
         d.last = 1'b0;
         expected_q.push_back(d);
      endfunction

      // A byte seen with no sequence open.
      function void start_fresh(utf8sd_pkg::byte_type b);
         if (b == 8'h00) begin
            push(utf8sd_pkg::KIND_END, '0);
         end else if (b < utf8sd_pkg::CONT_TAG) begin
            push(utf8sd_pkg::KIND_CP, utf8sd_pkg::cp_type'(b));
         end else if (b >= utf8sd_pkg::LEAD2_LO && b <= utf8sd_pkg::LEAD2_HI) begin
            seq_len = utf8sd_pkg::LEN_TWO;
            seq_bits = utf8sd_pkg::cp_type'(b[4:0]);
            seq_taken = 3'd1;
         end else if (b >= utf8sd_pkg::LEAD3_LO && b <= utf8sd_pkg::LEAD3_HI) begin
            seq_len = utf8sd_pkg::LEN_THREE;
            seq_bits = utf8sd_pkg::cp_type'(b[3:0]);
            seq_taken = 3'd1;
         end else if (b >= utf8sd_pkg::LEAD4_LO && b <= utf8sd_pkg::LEAD4_HI) begin
            seq_len = utf8sd_pkg::LEN_FOUR;
            seq_bits = utf8sd_pkg::cp_type'(b[2:0]);
            seq_taken = 3'd1;
         end else begin
            push(utf8sd_pkg::KIND_ERR, '0);
         end
      endfunction

      function void note_byte(utf8sd_pkg::byte_type b);
         int                    size_at_entry;
         utf8sd_pkg::len_type   done_len;
         utf8sd_pkg::count_type dropped;
         utf8sd_pkg::cp_type    lowest;
         decoded_type           tail;
         size_at_entry = expected_q.size();
         if (seq_len == utf8sd_pkg::LEN_NONE) begin
            start_fresh(b);
         end else if ((b & utf8sd_pkg::CONT_MASK) == utf8sd_pkg::CONT_TAG) begin
            seq_bits = {seq_bits[14:0], b[5:0]};
            seq_taken = seq_taken + 3'd1;
            if (seq_taken >= seq_len) begin
               done_len = seq_len;
               lowest = (done_len == utf8sd_pkg::LEN_TWO) ? utf8sd_pkg::MIN_TWO :
                        (done_len == utf8sd_pkg::LEN_THREE) ? utf8sd_pkg::MIN_THREE :
                        utf8sd_pkg::MIN_FOUR;
               if (seq_bits < lowest ||
                   (seq_bits >= utf8sd_pkg::SURR_LO && seq_bits <= utf8sd_pkg::SURR_HI) ||
                   seq_bits > utf8sd_pkg::CP_MAX) begin
                  repeat (done_len) push(utf8sd_pkg::KIND_ERR, '0);
               end else begin
                  push(utf8sd_pkg::KIND_CP, seq_bits);
               end
               clear_seq();
            end
         end else begin
            // The open sequence is abandoned: one error per byte it had taken,
            // then this byte starts over.
            dropped = seq_taken;
            clear_seq();
            repeat (dropped) push(utf8sd_pkg::KIND_ERR, '0);
            start_fresh(b);
         end
         if (expected_q.size() > size_at_entry) begin
            tail = expected_q.pop_back();
            tail.last = 1'b1;
            expected_q.push_back(tail);
         end
      endfunction

      function void check_result(utf8sd_pkg::kind_type k, utf8sd_pkg::cp_type cp,
                                 logic last);
         decoded_type want;
         checked++;
         case (k)
            utf8sd_pkg::KIND_CP: n_cp++;
            utf8sd_pkg::KIND_ERR: n_err++;
            default: n_end++;
         endcase
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat kind %s cp %h last %b",
                     $time, k.name(), cp, last);
            return;
         end
         want = expected_q.pop_front();
         if (want.kind != k) begin
            mismatches++;
            $display("%0t: kind mismatch, expected %s, actual %s",
                     $time, want.kind.name(), k.name());
         end
         if (want.code_point != cp) begin
            mismatches++;
            $display("%0t: code_point mismatch, expected %h, actual %h",
                     $time, want.code_point, cp);
         end
         if (want.last != last) begin
            mismatches++;
            $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   utf8sd_req_if req_chan();
   utf8sd_rsp_if rsp_chan();

   utf8_stream_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   utf8_scoreboard_type sb = new();

   bit                   idle_on = 1'b1;
   int                   holds_asked = 0;
   int                   holds_done = 0;
   int                   bytes_sent = 0;
   int                   stall_cycles = 0;
   utf8sd_pkg::byte_type text_bytes[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < holds_asked) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result(rsp_chan.kind, rsp_chan.code_point, rsp_chan.last);
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_byte(input utf8sd_pkg::byte_type b);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i]);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void push_utf8(utf8sd_pkg::cp_type cp, int len);
      case (len)
         1: text_bytes.push_back(cp[7:0]);
         2: begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // Stall the result side while four-beat error bursts keep coming, so the
   // decoder has to push back on its input.
   task automatic apply_pressure();
      holds_asked++;
      text_bytes.delete();
      repeat (4) begin
         push_utf8(21'h010000, 4);
         void'(text_bytes.pop_back());
         text_bytes.push_back(8'hFF);
      end
      send_text();
      wait_drained();
   endtask

   task automatic run_random(input int total);
      int                 sent;
      int                 pick;
      int                 len;
      utf8sd_pkg::cp_type cp;
      bit                 pressed;
      sent = 0;
      pressed = 1'b0;
      while (sent < total) begin
         if (sent >= total - QUIET_TAIL)
            idle_on = 1'b0;
         if (!pressed && sent >= total / 3) begin
            apply_pressure();
            pressed = 1'b1;
         end
         text_bytes.delete();
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            push_utf8(utf8sd_pkg::cp_type'($urandom_range(1, 'h7F)), 1);
         end else if (pick < 50) begin
            push_utf8(utf8sd_pkg::cp_type'($urandom_range('h80, 'h7FF)), 2);
         end else if (pick < 62) begin
            do cp = utf8sd_pkg::cp_type'($urandom_range('h800, 'hFFFF));
            while (cp >= utf8sd_pkg::SURR_LO && cp <= utf8sd_pkg::SURR_HI);
            push_utf8(cp, 3);
         end else if (pick < 72) begin
            push_utf8(utf8sd_pkg::cp_type'($urandom_range('h10000, 'h10FFFF)), 4);
         end else if (pick < 76) begin
            text_bytes.push_back(8'h00);
         end else if (pick < 82) begin
            // Well-formed bytes that decode to an overlong, surrogate or
            // out-of-range value.
            case ($urandom_range(0, 3))
               0: push_utf8(utf8sd_pkg::cp_type'($urandom_range(0, 'h7FF)), 3);
               1: push_utf8(utf8sd_pkg::cp_type'($urandom_range(utf8sd_pkg::SURR_LO,
                                                                utf8sd_pkg::SURR_HI)), 3);
               2: push_utf8(utf8sd_pkg::cp_type'($urandom_range(0, 'hFFFF)), 4);
               default: push_utf8(utf8sd_pkg::cp_type'($urandom_range('h110000, 'h13FFFF)),
                                  4);
            endcase
         end else if (pick < 90) begin
            len = $urandom_range(2, 4);
            case (len)
               2: cp = utf8sd_pkg::cp_type'($urandom_range('h80, 'h7FF));
               3: cp = utf8sd_pkg::cp_type'($urandom_range('h800, 'hFFFF));
               default: cp = utf8sd_pkg::cp_type'($urandom_range('h10000, 'h10FFFF));
            endcase
            push_utf8(cp, len);
            repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
         end else begin
            text_bytes.push_back(utf8sd_pkg::byte_type'($urandom_range(0, 255)));
         end
         send_text();
         sent += text_bytes.size();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_TEXT[i]) send_byte(DIRECTED_TEXT[i]);
      wait_drained();

      run_random(RANDOM_BYTES);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes; checked %0d result beats (%0d code points, %0d errors, %0d ends).",
               bytes_sent, sb.checked, sb.n_cp, sb.n_err, sb.n_end);
      $display("Long result-side hold-offs: %0d; stalls on both sides, quiet tail at the end.",
               holds_done);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
